// ----- design/qmm_pkg.sv -----
`default_nettype none

package qmm_pkg;

    localparam int MOTOR_COUNT   = 4;
    localparam int PULSE_BITS    = 12;
    localparam int CFG_BITS      = 12;
    localparam int TIMER_BITS    = 16;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;
    localparam int TERM_BITS     = 16;

    localparam logic [PULSE_BITS-1:0] PULSE_TOP = '1;
    localparam logic [TIMER_BITS-1:0] TIMER_TOP = '1;

    // battery compensation: x / 3500 done as x * ceil(2^38 / 3500) >> 38,
    // exact for x below 2^26
    localparam int COMP_DIVISOR    = 3500;
    localparam int COMP_SHIFT      = 38;
    localparam int COMP_RECIP_BITS = 27;
    localparam int COMP_MAG_BITS   = 26;
    localparam int COMP_Q_BITS     = 14;
    localparam logic [63:0] COMP_RECIP_FULL =
        ((64'd1 << COMP_SHIFT) + 64'(COMP_DIVISOR - 1)) / 64'(COMP_DIVISOR);
    localparam logic [COMP_RECIP_BITS-1:0] COMP_RECIP =
        COMP_RECIP_FULL[COMP_RECIP_BITS-1:0];

    typedef enum logic [1:0] {
        FUNC_TICK = 2'd0,
        FUNC_MIX  = 2'd1,
        FUNC_OFF  = 2'd2,
        FUNC_SET  = 2'd3
    } t_func;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_THR_CAP      = 3'd0,
        CFG_BATTERY_HIGH = 3'd1,
        CFG_BATTERY_LOW  = 3'd2,
        CFG_ON_PULSE     = 3'd3,
        CFG_MAX_PULSE    = 3'd4,
        CFG_OFF_PULSE    = 3'd5,
        CFG_FRAME_PERIOD = 3'd6
    } t_cfg_idx;

    typedef logic [PULSE_BITS-1:0] t_pulse;

    typedef struct packed {
        logic [CFG_BITS-1:0]   thr_cap;
        logic [CFG_BITS-1:0]   battery_high;
        logic [CFG_BITS-1:0]   battery_low;
        logic [CFG_BITS-1:0]   on_pulse;
        logic [CFG_BITS-1:0]   max_pulse;
        logic [CFG_BITS-1:0]   off_pulse;
        logic [TIMER_BITS-1:0] frame_period;
    } t_cfg;

    // mixer output toward the PWM core: truncated sums and the signed
    // compensation step per motor
    typedef struct packed {
        t_func                         func;
        logic [1:0]                    motor_index;
        logic [TERM_BITS-1:0]          pulse_value;
        logic                          comp_en;
        logic [MOTOR_COUNT-1:0][14:0]  p;
        logic [MOTOR_COUNT-1:0][14:0]  q;
    } t_mix_word;

endpackage

`default_nettype wire

// ----- design/qmm_if.sv -----
`default_nettype none

interface qmm_in_if import qmm_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic [1:0]                  func;
    logic [PULSE_BITS-1:0]       throttle;
    logic signed [TERM_BITS-1:0] roll_term;
    logic signed [TERM_BITS-1:0] pitch_term;
    logic signed [TERM_BITS-1:0] yaw_term;
    logic [CFG_BITS-1:0]         battery_level;
    logic [1:0]                  motor_index;
    logic signed [TERM_BITS-1:0] pulse_value;

    modport source (output valid, func, throttle, roll_term, pitch_term, yaw_term,
                    battery_level, motor_index, pulse_value, input ready);
    modport sink   (input valid, func, throttle, roll_term, pitch_term, yaw_term,
                    battery_level, motor_index, pulse_value, output ready);
endinterface

interface qmm_out_if import qmm_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [MOTOR_COUNT-1:0] motor_pins;
    logic                   frame_start;
    logic [PULSE_BITS-1:0]  pulse_front_right;
    logic [PULSE_BITS-1:0]  pulse_front_left;
    logic [PULSE_BITS-1:0]  pulse_rear_right;
    logic [PULSE_BITS-1:0]  pulse_rear_left;
    logic                   all_low;

    modport source (output valid, motor_pins, frame_start, pulse_front_right,
                    pulse_front_left, pulse_rear_right, pulse_rear_left, all_low,
                    input ready);
    modport sink   (input valid, motor_pins, frame_start, pulse_front_right,
                    pulse_front_left, pulse_rear_right, pulse_rear_left, all_low,
                    output ready);
endinterface

interface qmm_cfg_if import qmm_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- design/qmm_cfg_regs.sv -----
`default_nettype none

module qmm_cfg_regs import qmm_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    qmm_cfg_if.sink   i_cfg,
    output t_cfg      o_cfg
);

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.thr_cap      <= CFG_BITS'(1800);
            r_cfg.battery_high <= CFG_BITS'(1260);
            r_cfg.battery_low  <= CFG_BITS'(1000);
            r_cfg.on_pulse     <= CFG_BITS'(1100);
            r_cfg.max_pulse    <= CFG_BITS'(2000);
            r_cfg.off_pulse    <= CFG_BITS'(1000);
            r_cfg.frame_period <= TIMER_BITS'(4000);
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_THR_CAP:      r_cfg.thr_cap      <= i_cfg.data[CFG_BITS-1:0];
                CFG_BATTERY_HIGH: r_cfg.battery_high <= i_cfg.data[CFG_BITS-1:0];
                CFG_BATTERY_LOW:  r_cfg.battery_low  <= i_cfg.data[CFG_BITS-1:0];
                CFG_ON_PULSE:     r_cfg.on_pulse     <= i_cfg.data[CFG_BITS-1:0];
                CFG_MAX_PULSE:    r_cfg.max_pulse    <= i_cfg.data[CFG_BITS-1:0];
                CFG_OFF_PULSE:    r_cfg.off_pulse    <= i_cfg.data[CFG_BITS-1:0];
                CFG_FRAME_PERIOD: r_cfg.frame_period <= i_cfg.data[TIMER_BITS-1:0];
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- design/qmm_mix_pipe.sv -----
`default_nettype none

module qmm_mix_pipe import qmm_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    qmm_in_if.sink    i_mix,
    input  wire t_cfg i_cfg,
    input  wire logic i_down_ready,
    output logic      o_valid,
    output t_mix_word o_word
);

    typedef struct packed {
        t_func                 func;
        logic [PULSE_BITS-1:0] throttle;
        logic [TERM_BITS-1:0]  roll_term;
        logic [TERM_BITS-1:0]  pitch_term;
        logic [TERM_BITS-1:0]  yaw_term;
        logic [CFG_BITS-1:0]   battery_level;
        logic [1:0]            motor_index;
        logic [TERM_BITS-1:0]  pulse_value;
    } t_in_word;

    typedef struct packed {
        t_func                        func;
        logic [1:0]                   motor_index;
        logic [TERM_BITS-1:0]         pulse_value;
        logic                         comp_en;
        logic [MOTOR_COUNT-1:0][14:0] p;
        logic [MOTOR_COUNT-1:0][26:0] prod;
    } t_prod_word;

    logic       r_s1_valid, r_s2_valid, r_s3_valid;
    t_in_word   r_s1;
    t_prod_word r_s2, n_s2;
    t_mix_word  r_s3, n_s3;
    logic       rdy1, rdy2, rdy3;

    // a stage takes a word when empty or when it hands its own word on
    assign rdy3        = !r_s3_valid || i_down_ready;
    assign rdy2        = !r_s2_valid || rdy3;
    assign rdy1        = !r_s1_valid || rdy2;
    assign i_mix.ready = rdy1;
    assign o_valid     = r_s3_valid;
    assign o_word      = r_s3;

    function automatic logic signed [18:0] sx19(input logic [TERM_BITS-1:0] v);
        sx19 = $signed({{3{v[TERM_BITS-1]}}, v});
    endfunction

    // stage 2: throttle cap, four sums, truncation, p * (high - level)
    always_comb begin
        logic [PULSE_BITS-1:0]   thr;
        logic signed [18:0]      t16, rl, pt, yw;
        logic signed [18:0]      sums [MOTOR_COUNT];
        logic signed [18:0]      rnd;
        logic [CFG_BITS-1:0]     diff;
        logic signed [27:0]      prod;
        thr = (r_s1.throttle > i_cfg.thr_cap) ? i_cfg.thr_cap : r_s1.throttle;
        t16 = $signed({3'b000, thr, 4'b0000});
        rl  = sx19(r_s1.roll_term);
        pt  = sx19(r_s1.pitch_term);
        yw  = sx19(r_s1.yaw_term);
        sums[0] = t16 - pt + rl - yw;
        sums[1] = t16 + pt + rl + yw;
        sums[2] = t16 + pt - rl - yw;
        sums[3] = t16 - pt - rl + yw;
        diff = i_cfg.battery_high - r_s1.battery_level;
        n_s2.func        = r_s1.func;
        n_s2.motor_index = r_s1.motor_index;
        n_s2.pulse_value = r_s1.pulse_value;
        n_s2.comp_en     = (r_s1.battery_level < i_cfg.battery_high) &&
                           (r_s1.battery_level > i_cfg.battery_low);
        for (int i = 0; i < MOTOR_COUNT; i++) begin
            // divide by 16 toward zero
            rnd = sums[i] + (sums[i][18] ? 19'sd15 : 19'sd0);
            n_s2.p[i] = rnd[18:4];
            prod = $signed(rnd[18:4]) * $signed({1'b0, diff});
            n_s2.prod[i] = prod[26:0];
        end
    end

    // stage 3: magnitude / 3500 via reciprocal, sign restored
    always_comb begin
        logic                     neg;
        logic [26:0]              negp;
        logic [COMP_MAG_BITS-1:0] mag;
        logic [52:0]              full;
        logic [COMP_Q_BITS-1:0]   qm;
        n_s3.func        = r_s2.func;
        n_s3.motor_index = r_s2.motor_index;
        n_s3.pulse_value = r_s2.pulse_value;
        n_s3.comp_en     = r_s2.comp_en;
        for (int i = 0; i < MOTOR_COUNT; i++) begin
            neg  = r_s2.prod[i][26];
            negp = 27'(-r_s2.prod[i]);
            mag  = neg ? negp[COMP_MAG_BITS-1:0] : r_s2.prod[i][COMP_MAG_BITS-1:0];
            full = 53'(mag) * 53'(COMP_RECIP);
            qm   = full[COMP_SHIFT+COMP_Q_BITS-1:COMP_SHIFT];
            n_s3.p[i] = r_s2.p[i];
            n_s3.q[i] = neg ? 15'(-{1'b0, qm}) : {1'b0, qm};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            if (rdy1) begin
                r_s1_valid <= i_mix.valid;
            end
            if (rdy2) begin
                r_s2_valid <= r_s1_valid;
            end
            if (rdy3) begin
                r_s3_valid <= r_s2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_s1.func          <= t_func'(i_mix.func);
            r_s1.throttle      <= i_mix.throttle;
            r_s1.roll_term     <= i_mix.roll_term;
            r_s1.pitch_term    <= i_mix.pitch_term;
            r_s1.yaw_term      <= i_mix.yaw_term;
            r_s1.battery_level <= i_mix.battery_level;
            r_s1.motor_index   <= i_mix.motor_index;
            r_s1.pulse_value   <= i_mix.pulse_value;
        end
        if (rdy2) begin
            r_s2 <= n_s2;
        end
        if (rdy3) begin
            r_s3 <= n_s3;
        end
    end

    // a word offered downstream holds until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s3_valid && !i_down_ready |=> r_s3_valid && $stable(r_s3))
        else $error("mixer word changed while stalled");

endmodule

`default_nettype wire

// ----- design/qmm_pwm_core.sv -----
`default_nettype none

module qmm_pwm_core import qmm_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_cfg      i_cfg,
    input  wire logic      i_valid,
    input  wire t_mix_word i_word,
    output logic           o_ready,
    qmm_out_if.source      o_res
);

    typedef struct packed {
        logic [MOTOR_COUNT-1:0]   motor_pins;
        logic                     frame_start;
        t_pulse [MOTOR_COUNT-1:0] pulse;
    } t_res;

    t_pulse [MOTOR_COUNT-1:0] r_motor_pulse, n_motor_pulse;
    t_pulse [MOTOR_COUNT-1:0] r_latched, n_latched;
    logic [TIMER_BITS-1:0]    r_elapsed, n_elapsed;
    logic                     r_out_valid;
    t_res                     r_out, n_out;
    logic                     fire;
    logic                     start;

    assign o_ready = !r_out_valid || o_res.ready;
    assign fire    = i_valid && o_ready;

    assign o_res.valid             = r_out_valid;
    assign o_res.motor_pins        = r_out.motor_pins;
    assign o_res.frame_start       = r_out.frame_start;
    assign o_res.pulse_front_right = r_out.pulse[0];
    assign o_res.pulse_front_left  = r_out.pulse[1];
    assign o_res.pulse_rear_right  = r_out.pulse[2];
    assign o_res.pulse_rear_left   = r_out.pulse[3];
    assign o_res.all_low           = (r_out.motor_pins == '0);

    always_comb begin
        logic signed [15:0]     v, lo, hi;
        t_pulse                 mixed [MOTOR_COUNT];
        t_pulse                 direct;
        logic [MOTOR_COUNT-1:0] pins_old;
        logic [TIMER_BITS-1:0]  base;
        lo = $signed({4'b0000, i_cfg.on_pulse});
        hi = $signed({4'b0000, i_cfg.max_pulse});
        for (int i = 0; i < MOTOR_COUNT; i++) begin
            v = $signed({i_word.p[i][14], i_word.p[i]});
            if (i_word.comp_en) begin
                v = v + $signed({i_word.q[i][14], i_word.q[i]});
            end
            // lower limit wins when the limits cross
            if (v < lo) begin
                mixed[i] = i_cfg.on_pulse;
            end else if (v > hi) begin
                mixed[i] = i_cfg.max_pulse;
            end else begin
                mixed[i] = v[PULSE_BITS-1:0];
            end
        end

        if (i_word.pulse_value[TERM_BITS-1]) begin
            direct = '0;
        end else if (i_word.pulse_value > TERM_BITS'(PULSE_TOP)) begin
            direct = PULSE_TOP;
        end else begin
            direct = i_word.pulse_value[PULSE_BITS-1:0];
        end

        n_motor_pulse = r_motor_pulse;
        case (i_word.func)
            FUNC_MIX: begin
                for (int i = 0; i < MOTOR_COUNT; i++) begin
                    n_motor_pulse[i] = mixed[i];
                end
            end
            FUNC_OFF: begin
                for (int i = 0; i < MOTOR_COUNT; i++) begin
                    n_motor_pulse[i] = i_cfg.off_pulse;
                end
            end
            FUNC_SET: n_motor_pulse[i_word.motor_index] = direct;
            default: ;
        endcase

        // frame start only once the period is over and every pin is low
        for (int i = 0; i < MOTOR_COUNT; i++) begin
            pins_old[i] = r_elapsed < TIMER_BITS'(r_latched[i]);
        end
        start = (i_word.func == FUNC_TICK) && (r_elapsed >= i_cfg.frame_period) &&
                (pins_old == '0);
        n_latched = start ? r_motor_pulse : r_latched;
        base      = start ? '0 : r_elapsed;

        for (int i = 0; i < MOTOR_COUNT; i++) begin
            n_out.motor_pins[i] = base < TIMER_BITS'(n_latched[i]);
        end
        n_out.frame_start = start;
        n_out.pulse       = n_motor_pulse;

        if (i_word.func == FUNC_TICK && base != TIMER_TOP) begin
            n_elapsed = base + TIMER_BITS'(1);
        end else begin
            n_elapsed = base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motor_pulse <= '0;
            r_latched     <= '0;
            r_elapsed     <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (fire) begin
                r_motor_pulse <= n_motor_pulse;
                r_latched     <= n_latched;
                r_elapsed     <= n_elapsed;
                r_out_valid   <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= n_out;
        end
    end

    a_start_pins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.frame_start |->
            (r_out.motor_pins[0] == (r_latched[0] != '0)) &&
            (r_out.motor_pins[1] == (r_latched[1] != '0)) &&
            (r_out.motor_pins[2] == (r_latched[2] != '0)) &&
            (r_out.motor_pins[3] == (r_latched[3] != '0)))
        else $error("pins at frame start do not follow latched pulses");

    a_start_timer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && start |=> r_elapsed == TIMER_BITS'(1))
        else $error("timer not restarted at frame start");

    a_no_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && i_word.func != FUNC_TICK |=> $stable(r_elapsed) && $stable(r_latched))
        else $error("timing state moved on a non-tick word");

endmodule

`default_nettype wire

// ----- design/quad_motor_mixer_pwm.sv -----
// Quad X motor mixer with ESC pulse generation.
// Channels:
//   i_mix  - command words (tick / mix / all off / set one motor), valid-ready.
//   o_res  - one result word per command: pin states, frame start flag,
//            the four stored pulse widths and an all-low flag, valid-ready.
//   i_cfg  - register writes (index, data); always ready. Write only while
//            no command is in flight.
// Path: an accepted command passes the input register, the product stage, the
//   reciprocal divide stage, then the timing state and the output register.
// Throughput: one word per cycle while o_res is taken; the two multiplier stages set the depth.
// Reset (sync, active low): registers return to defaults, stored and
//   latched pulses and the frame timer go to zero, the pipe empties.
// Stalls: when o_res is not taken, each stage keeps accepting until it is
//   full, so up to four words sit in the block before i_mix.ready drops.
`default_nettype none

module quad_motor_mixer_pwm import qmm_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    qmm_in_if.sink    i_mix,
    qmm_cfg_if.sink   i_cfg,
    qmm_out_if.source o_res
);

    t_cfg      cfg;
    logic      mix_valid;
    t_mix_word mix_word;
    logic      core_ready;

    // register file
    qmm_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    // stateless mixer arithmetic: sums, battery scaling products, divide
    qmm_mix_pipe u_mix (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_mix        (i_mix),
        .i_cfg        (cfg),
        .i_down_ready (core_ready),
        .o_valid      (mix_valid),
        .o_word       (mix_word)
    );

    // clamp, stored pulses, frame timer and pin logic; all pulse and timer state lives here
    // so consecutive words always see each other's updates in order
    qmm_pwm_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (mix_valid),
        .i_word  (mix_word),
        .o_ready (core_ready),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire

// ----- tb/quad_motor_mixer_pwm_tb.sv -----
`timescale 1ns / 100ps

module quad_motor_mixer_pwm_tb;
    import qmm_pkg::*;

    // index with no register behind it; writes there must change nothing
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_IDX = 3'd7;

    // one command word as the mixer sees it
    typedef struct packed {
        t_func                       func;
        logic [PULSE_BITS-1:0]       throttle;
        logic signed [TERM_BITS-1:0] roll;
        logic signed [TERM_BITS-1:0] pitch;
        logic signed [TERM_BITS-1:0] yaw;
        logic [CFG_BITS-1:0]         battery;
        logic [1:0]                  motor;
        logic signed [TERM_BITS-1:0] pulse_value;
    } t_esc_cmd;

    // one result word: pins, frame flag, stored widths, all-low flag
    typedef struct packed {
        logic [MOTOR_COUNT-1:0]          pins;
        logic                            frame_start;
        t_pulse [MOTOR_COUNT-1:0]        pw;
        logic                            all_low;
    } t_esc_res;

    logic i_clk = 1'b0;
    logic i_rst_n;

    qmm_in_if  mix_if ();
    qmm_cfg_if cfg_if ();
    qmm_out_if res_if ();

    quad_motor_mixer_pwm u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mix   (mix_if),
        .i_cfg   (cfg_if),
        .o_res   (res_if)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: register copies, stored and latched pulse widths,
    // the frame timer. Reset values match the block's defaults.
    // ------------------------------------------------------------------
    logic [CFG_BITS-1:0]   r_max_thr   = 12'd1800;
    logic [CFG_BITS-1:0]   r_batt_hi   = 12'd1260;
    logic [CFG_BITS-1:0]   r_batt_lo   = 12'd1000;
    logic [CFG_BITS-1:0]   r_on_pw     = 12'd1100;
    logic [CFG_BITS-1:0]   r_max_pw    = 12'd2000;
    logic [CFG_BITS-1:0]   r_off_pw    = 12'd1000;
    logic [TIMER_BITS-1:0] r_frame_len = 16'd4000;

    t_pulse                stored_pw [MOTOR_COUNT] = '{default: '0};
    t_pulse                frame_pw  [MOTOR_COUNT] = '{default: '0};
    logic [TIMER_BITS-1:0] frame_timer = '0;

    t_esc_cmd cmd_q [$];      // words waiting for the driver
    t_esc_res esc_due_q [$];  // predicted results, oldest first

    int  cnt_queued, cnt_accepted, cnt_results, cnt_frames, cnt_writes, cnt_fail;
    bit  calm;                // no random idling on either side
    bit  cmd_fire, cfg_fire;  // handshakes seen at the last rising edge
    int  hold_left;
    bit  hold_done;
    t_esc_cmd nxt;

    // pins follow the timer against the widths latched at frame start
    function automatic logic [MOTOR_COUNT-1:0] pins_high();
        logic [MOTOR_COUNT-1:0] pins;
        int i;
        pins = '0;
        for (i = 0; i < MOTOR_COUNT; i++)
            if (frame_timer < TIMER_BITS'(frame_pw[i]))
                pins[i] = 1'b1;
        return pins;
    endfunction

    function automatic t_esc_res esc_step(t_esc_cmd c);
        t_esc_res r;
        logic [MOTOR_COUNT-1:0] pins;
        int thr, base, lvl, p, v, i;
        int sum [MOTOR_COUNT];
        r = '0;
        case (c.func)
            FUNC_TICK: begin
                // a new frame needs the period elapsed and every pin low
                if (frame_timer >= r_frame_len && pins_high() == '0) begin
                    for (i = 0; i < MOTOR_COUNT; i++)
                        frame_pw[i] = stored_pw[i];
                    frame_timer = '0;
                    r.frame_start = 1'b1;
                end
            end
            FUNC_MIX: begin
                thr = int'(c.throttle);
                if (thr > int'(r_max_thr))
                    thr = int'(r_max_thr);
                base = thr * 16;
                // X layout: FR, FL, RR, RL
                sum[0] = base - int'(c.pitch) + int'(c.roll) - int'(c.yaw);
                sum[1] = base + int'(c.pitch) + int'(c.roll) + int'(c.yaw);
                sum[2] = base + int'(c.pitch) - int'(c.roll) - int'(c.yaw);
                sum[3] = base - int'(c.pitch) - int'(c.roll) + int'(c.yaw);
                lvl = int'(c.battery);
                for (i = 0; i < MOTOR_COUNT; i++) begin
                    p = sum[i] / 16;
                    if (lvl < int'(r_batt_hi) && lvl > int'(r_batt_lo))
                        p = p + p * (int'(r_batt_hi) - lvl) / COMP_DIVISOR;
                    // lower bound tested first, so under crossed limits a value below on_pulse gives on_pulse
                    if (p < int'(r_on_pw))
                        p = int'(r_on_pw);
                    else if (p > int'(r_max_pw))
                        p = int'(r_max_pw);
                    stored_pw[i] = t_pulse'(p);
                end
            end
            FUNC_OFF: begin
                for (i = 0; i < MOTOR_COUNT; i++)
                    stored_pw[i] = r_off_pw;
            end
            FUNC_SET: begin
                v = int'(c.pulse_value);
                if (v < 0)
                    v = 0;
                else if (v > int'(PULSE_TOP))
                    v = int'(PULSE_TOP);
                stored_pw[c.motor] = t_pulse'(v);
            end
            default: ;
        endcase
        pins = pins_high();
        // timer moves on ticks only and sticks at its top
        if (c.func == FUNC_TICK && frame_timer != TIMER_TOP)
            frame_timer = frame_timer + 1'b1;
        r.pins = pins;
        for (i = 0; i < MOTOR_COUNT; i++)
            r.pw[i] = stored_pw[i];
        r.all_low = (pins == '0);
        return r;
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_BITS-1:0] idx,
                                      logic [CFG_DATA_BITS-1:0] data);
        case (idx)
            CFG_THR_CAP:      r_max_thr   = data[CFG_BITS-1:0];
            CFG_BATTERY_HIGH: r_batt_hi   = data[CFG_BITS-1:0];
            CFG_BATTERY_LOW:  r_batt_lo   = data[CFG_BITS-1:0];
            CFG_ON_PULSE:     r_on_pw     = data[CFG_BITS-1:0];
            CFG_MAX_PULSE:    r_max_pw    = data[CFG_BITS-1:0];
            CFG_OFF_PULSE:    r_off_pw    = data[CFG_BITS-1:0];
            CFG_FRAME_PERIOD: r_frame_len = data;
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Rising edge: take accepted words into the predictor. Register
    // writes update the register copies at the same edge the block sees.
    // Outputs are registered, so a result never pops the entry pushed
    // at its own edge.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_esc_cmd c;
        cmd_fire <= i_rst_n && mix_if.valid && mix_if.ready;
        cfg_fire <= i_rst_n && cfg_if.valid && cfg_if.ready;
        if (i_rst_n && cfg_if.valid && cfg_if.ready) begin
            apply_reg(cfg_if.index, cfg_if.data);
            cnt_writes++;
        end
        if (i_rst_n && mix_if.valid && mix_if.ready) begin
            c.func        = t_func'(mix_if.func);
            c.throttle    = mix_if.throttle;
            c.roll        = mix_if.roll_term;
            c.pitch       = mix_if.pitch_term;
            c.yaw         = mix_if.yaw_term;
            c.battery     = mix_if.battery_level;
            c.motor       = mix_if.motor_index;
            c.pulse_value = mix_if.pulse_value;
            esc_due_q.push_back(esc_step(c));
            cnt_accepted++;
        end
    end

    // ------------------------------------------------------------------
    // Driver: new word at the falling edge once the current one is taken
    // or none is up. About one cycle in eight it idles unless calm.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            mix_if.valid <= 1'b0;
        end else if (!mix_if.valid || cmd_fire) begin
            if (cmd_q.size() != 0 && (calm || $urandom_range(99) >= 12)) begin
                nxt = cmd_q.pop_front();
                mix_if.func          <= nxt.func;
                mix_if.throttle      <= nxt.throttle;
                mix_if.roll_term     <= nxt.roll;
                mix_if.pitch_term    <= nxt.pitch;
                mix_if.yaw_term      <= nxt.yaw;
                mix_if.battery_level <= nxt.battery;
                mix_if.motor_index   <= nxt.motor;
                mix_if.pulse_value   <= nxt.pulse_value;
                mix_if.valid         <= 1'b1;
            end else begin
                mix_if.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result ready: random stalls, plus one long hold-off the first time
    // a big batch is waiting, so the pipe fills and i_mix.ready drops.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            res_if.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end else if (!hold_done && cmd_q.size() >= 100) begin
            res_if.ready <= 1'b0;
            hold_left    <= 150;
            hold_done    <= 1'b1;
        end else begin
            res_if.ready <= calm || ($urandom_range(99) >= 12);
        end
    end

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            cnt_fail++;
            $error("%s: expected %0d, got %0d", name, want, got);
        end
    endtask

    // Monitor: each result word against the oldest prediction
    always @(posedge i_clk) begin
        t_esc_res e;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            cnt_results++;
            if (esc_due_q.size() == 0) begin
                cnt_fail++;
                $error("result word with no command outstanding");
            end else begin
                e = esc_due_q.pop_front();
                if (e.frame_start)
                    cnt_frames++;
                check_field("motor_pins",        16'(e.pins),        16'(res_if.motor_pins));
                check_field("frame_start",       16'(e.frame_start), 16'(res_if.frame_start));
                check_field("pulse_front_right", 16'(e.pw[0]), 16'(res_if.pulse_front_right));
                check_field("pulse_front_left",  16'(e.pw[1]), 16'(res_if.pulse_front_left));
                check_field("pulse_rear_right",  16'(e.pw[2]), 16'(res_if.pulse_rear_right));
                check_field("pulse_rear_left",   16'(e.pw[3]), 16'(res_if.pulse_rear_left));
                check_field("all_low",           16'(e.all_low),     16'(res_if.all_low));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers. Fields a command does not use stay random.
    // ------------------------------------------------------------------
    function automatic t_esc_cmd rand_cmd();
        t_esc_cmd c;
        c.func        = t_func'($urandom_range(3));
        c.throttle    = PULSE_BITS'($urandom);
        c.roll        = TERM_BITS'($urandom);
        c.pitch       = TERM_BITS'($urandom);
        c.yaw         = TERM_BITS'($urandom);
        c.battery     = CFG_BITS'($urandom);
        c.motor       = 2'($urandom);
        c.pulse_value = TERM_BITS'($urandom);
        return c;
    endfunction

    // correction term within about +-64 us
    function automatic logic signed [TERM_BITS-1:0] small_term();
        return TERM_BITS'(int'($urandom_range(2047)) - 1024);
    endfunction

    task automatic push_cmd(t_esc_cmd c);
        cmd_q.push_back(c);
        cnt_queued++;
    endtask

    task automatic do_mix(int thr, int roll, int pitch, int yaw, int batt);
        t_esc_cmd c;
        c = rand_cmd();
        c.func     = FUNC_MIX;
        c.throttle = PULSE_BITS'(thr);
        c.roll     = TERM_BITS'(roll);
        c.pitch    = TERM_BITS'(pitch);
        c.yaw      = TERM_BITS'(yaw);
        c.battery  = CFG_BITS'(batt);
        push_cmd(c);
    endtask

    task automatic do_set(int motor, int value);
        t_esc_cmd c;
        c = rand_cmd();
        c.func        = FUNC_SET;
        c.motor       = 2'(motor);
        c.pulse_value = TERM_BITS'(value);
        push_cmd(c);
    endtask

    task automatic do_off();
        t_esc_cmd c;
        c = rand_cmd();
        c.func = FUNC_OFF;
        push_cmd(c);
    endtask

    task automatic do_tick(int count);
        t_esc_cmd c;
        repeat (count) begin
            c = rand_cmd();
            c.func = FUNC_TICK;
            push_cmd(c);
        end
    endtask

    // mostly ticks so frames run; mixes either realistic or wild
    task automatic random_phase(int count, int pw_top);
        t_esc_cmd c;
        int roll;
        repeat (count) begin
            c = rand_cmd();
            roll = $urandom_range(99);
            if (roll < 55) begin
                c.func = FUNC_TICK;
            end else if (roll < 75) begin
                c.func = FUNC_MIX;
                if ($urandom_range(1))
                    c.throttle = PULSE_BITS'($urandom_range(pw_top));
                if ($urandom_range(1)) begin
                    c.roll  = small_term();
                    c.pitch = small_term();
                    c.yaw   = small_term();
                end
                if ($urandom_range(1) && r_batt_lo < r_batt_hi)
                    c.battery = CFG_BITS'($urandom_range(r_batt_hi, r_batt_lo));
            end else if (roll < 80) begin
                c.func = FUNC_OFF;
            end else begin
                c.func = FUNC_SET;
                if (roll < 94)
                    c.pulse_value = TERM_BITS'($urandom_range(pw_top));
            end
            push_cmd(c);
        end
    endtask

    // idle once every queued word is in and every result is out
    task automatic wait_idle();
        while (cnt_accepted != cnt_queued || esc_due_q.size() != 0)
            @(negedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    // valid drops for a cycle between writes so no stale word repeats
    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, int value);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= CFG_DATA_BITS'(value);
        @(negedge i_clk);
        while (!cfg_fire)
            @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic load_regs(int thr, int bhi, int blo, int on, int mx, int off, int len);
        write_reg(CFG_THR_CAP,      thr);
        write_reg(CFG_BATTERY_HIGH, bhi);
        write_reg(CFG_BATTERY_LOW,  blo);
        write_reg(CFG_ON_PULSE,     on);
        write_reg(CFG_MAX_PULSE,    mx);
        write_reg(CFG_OFF_PULSE,    off);
        write_reg(CFG_FRAME_PERIOD, len);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int lo;
        i_rst_n              = 1'b0;
        mix_if.valid         = 1'b0;
        mix_if.func          = '0;
        mix_if.throttle      = '0;
        mix_if.roll_term     = '0;
        mix_if.pitch_term    = '0;
        mix_if.yaw_term      = '0;
        mix_if.battery_level = '0;
        mix_if.motor_index   = '0;
        mix_if.pulse_value   = '0;
        cfg_if.valid         = 1'b0;
        cfg_if.index         = '0;
        cfg_if.data          = '0;
        res_if.ready         = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        // defaults: zero and full-scale mixes, throttle cap, battery at and
        // just inside both limits, all off, direct sets in and out of range
        do_mix(0, 0, 0, 0, 0);
        do_mix(4095, 32767, -32768, 32767, 4095);
        do_mix(1500, -32768, 32767, -32768, 1100);
        do_mix(1400, 100, -50, 33, 1259);
        do_mix(1400, 100, -50, 33, 1260);
        do_mix(1400, -7, -9, 5, 1000);
        do_mix(1400, -7, -9, 5, 1001);
        do_off();
        do_set(0, -1);
        do_set(1, 32767);
        do_set(2, 4096);
        do_set(3, 4095);
        do_set(0, -32768);
        do_set(1, 0);
        do_tick(3);
        wait_idle();

        // crossed clamp limits, zero frame period, upper data bits dropped
        // on 12-bit registers, a write to the spare index
        load_regs(16'hFFFF, 1260, 1000, 16'hFBB8, 100, 0, 0);
        write_reg(CFG_SPARE_IDX, 16'h0123);
        do_mix(1000, 0, 0, 0, 0);
        do_mix(0, -32768, -32768, -32768, 1100);
        do_set(0, 0);
        do_set(1, 0);
        do_set(2, 0);
        do_set(3, 5);
        // frame starts at once, then pin 3 overruns the zero period
        do_tick(4);
        do_set(3, 2);
        do_tick(4);
        do_off();
        do_tick(2);
        wait_idle();

        // random phases over a spread of settings
        load_regs(4095, 4095, 0, 0, 4095, 4095, 1);
        random_phase(225, 300);
        wait_idle();

        load_regs(0, 0, 0, 0, 0, 0, 2);
        random_phase(225, 20);
        wait_idle();

        calm = 1'b1;
        load_regs($urandom_range(4095), 1260, 1000, $urandom_range(20, 5),
                  $urandom_range(60, 30), $urandom_range(40), $urandom_range(90, 40));
        random_phase(225, 60);
        wait_idle();
        calm = 1'b0;

        lo = $urandom_range(2000);
        load_regs($urandom_range(4095, 1800), $urandom_range(4095, lo + 1), lo,
                  1000, $urandom_range(4095, 2000), 1000, 3000);
        random_phase(225, 2500);
        wait_idle();

        load_regs($urandom_range(4095), $urandom_range(4095), $urandom_range(4095),
                  $urandom_range(4095), $urandom_range(4095), $urandom_range(4095),
                  $urandom_range(65535));
        random_phase(225, 4095);
        wait_idle();

        load_regs($urandom_range(4095), 3000, 500, 40, 10, 25, $urandom_range(20));
        random_phase(225, 50);
        wait_idle();

        if (esc_due_q.size() != 0)
            cnt_fail++;
        $display("Ran %0d command words, %0d results checked, %0d frame starts, %0d reg writes.",
                 cnt_accepted, cnt_results, cnt_frames, cnt_writes);
        $display("Covered mix clamps, battery sag, direct sets, frame overrun, back-pressure.");
        if (cnt_fail == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // watchdog, far above the slowest legal run
    initial begin
        #4_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
